/* hdl/ndst_pkg.sv */
// ----------------------------------------------------------------------------
// ndst_pkg: shared definitions for the nearest departure sorted table
// Table depth, field widths, codes and the types passed between the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MIN_W       = 11;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [MIN_W-1:0] dep;
    logic [MIN_W-1:0] arr;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/ndst_req_if.sv */
// ----------------------------------------------------------------------------
// ndst_req_if: request channel of the nearest departure sorted table
// Carries one insert or query transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ndst_req_if import ndst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [MIN_W-1:0] departure_minute;
  logic [MIN_W-1:0] arrival_minute;
  logic [MIN_W-1:0] query_minute;

  modport source (
    output valid, action, departure_minute, arrival_minute, query_minute,
    input  ready
  );
  modport sink (
    input  valid, action, departure_minute, arrival_minute, query_minute,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/ndst_rsp_if.sv */
// ----------------------------------------------------------------------------
// ndst_rsp_if: response channel of the nearest departure sorted table
// Carries one result transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ndst_rsp_if import ndst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] found_departure;
  logic [MIN_W-1:0] found_arrival;
  logic [1:0]       status;

  modport source (
    output valid, found_departure, found_arrival, status,
    input  ready
  );
  modport sink (
    input  valid, found_departure, found_arrival, status,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/ndst_cell.sv */
// ----------------------------------------------------------------------------
// ndst_cell: one slot of the sorted table
// Holds one entry; shifts up on an insert, rotates down during a query scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndst_cell import ndst_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [MIN_W-1:0] new_dep_i,
  input  wire logic [MIN_W-1:0] new_arr_i,
  input  wire entry_t           prev_entry_i,
  input  wire logic             prev_ge_i,
  input  wire entry_t           next_entry_i,
  output entry_t                entry_o,
  output logic                  ge_o
);

  entry_t entry_q, entry_d;
  logic   occupied;
  logic   at_end;

  assign occupied = {1'b0, cell_idx_i} < count_i;
  assign at_end   = {1'b0, cell_idx_i} == count_i;
  // This slot holds an entry that the new one must go ahead of.
  assign ge_o     = occupied && (entry_q.dep >= new_dep_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (prev_ge_i) begin
        entry_d = prev_entry_i;
      end else if (ge_o || at_end) begin
        entry_d.dep = new_dep_i;
        entry_d.arr = new_arr_i;
      end
    end else if (ctrl_i.rotate) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* hdl/nearest_departure_sorted_table_unit.sv */
// ----------------------------------------------------------------------------
// nearest_departure_sorted_table_unit: sorted departure table with lookup
// Inserts keep the table sorted; queries return the nearest departure.
// ----------------------------------------------------------------------------
// Sequence: an accepted insert goes through S_INSERT and a query through
// S_SCAN, one full rotation of the cell chain; then, as for an empty or full
// case, S_RESULT loads the output register once that register is free.
// Flow: one transaction at a time; queries are bound by the chain rotation.
// Reset: rst_ni clears the entry count, the controller and the output valid;
// table cells hold no reset value and are read only after they are written.
`timescale 1ns / 1ps
`default_nettype none

module nearest_departure_sorted_table_unit import ndst_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ndst_req_if.sink    req_i,
  ndst_rsp_if.source  rsp_o
);

  // Controller state and the latched request.
  state_e           state_q, state_d;
  logic             action_q;
  logic [MIN_W-1:0] dep_q;
  logic [MIN_W-1:0] arr_q;
  logic [MIN_W-1:0] qry_q;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] count_q;

  // Scan bookkeeping. The chain rotates one slot toward cell zero per cycle,
  // so on scan step k the head of the chain shows entry k. After TABLE_DEPTH
  // steps every entry is back in its own cell.
  logic [IDX_W-1:0] step_q;
  logic             found_q;
  entry_t           prev_q;
  entry_t           pick_q;

  // Output register.
  logic             out_valid_q;
  logic [MIN_W-1:0] out_dep_q;
  logic [MIN_W-1:0] out_arr_q;
  status_e          out_status_q;

  // Controller outputs.
  logic       accept;
  logic       load_out;
  cell_ctrl_t cell_ctrl;

  logic table_full;
  logic table_empty;
  assign table_full  = count_q == CNT_W'(TABLE_DEPTH);
  assign table_empty = count_q == '0;

  // --------------------------------------------------------------------------
  // Chain of cells. Each cell sees its lower neighbor for inserts (entries
  // move up to open a gap) and its upper neighbor for the scan rotation.
  // --------------------------------------------------------------------------
  entry_t cell_entry [TABLE_DEPTH];
  logic   cell_ge    [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_ge;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_ge    = 1'b0;
    end else begin : g_rest
      assign prev_entry = cell_entry[i-1];
      assign prev_ge    = cell_ge[i-1];
    end

    ndst_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (IDX_W'(i)),
      .count_i      (count_q),
      .ctrl_i       (cell_ctrl),
      .new_dep_i    (dep_q),
      .new_arr_i    (arr_q),
      .prev_entry_i (prev_entry),
      .prev_ge_i    (prev_ge),
      .next_entry_i (cell_entry[(i + 1) % TABLE_DEPTH]),
      .entry_o      (cell_entry[i]),
      .ge_o         (cell_ge[i])
    );
  end

  // --------------------------------------------------------------------------
  // Next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.action == ACT_INSERT) begin
            status_d = table_full ? ST_FULL : ST_INSERTED;
            state_d  = table_full ? S_RESULT : S_INSERT;
          end else begin
            status_d = table_empty ? ST_EMPTY : ST_MATCHED;
            state_d  = table_empty ? S_RESULT : S_SCAN;
          end
        end
      end
      S_INSERT: state_d = S_RESULT;
      S_SCAN: begin
        if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    accept           = 1'b0;
    load_out         = 1'b0;
    cell_ctrl.insert = 1'b0;
    cell_ctrl.rotate = 1'b0;
    case (state_q)
      S_IDLE:   accept = 1'b1;
      S_INSERT: cell_ctrl.insert = 1'b1;
      S_SCAN:   cell_ctrl.rotate = 1'b1;
      S_RESULT: load_out = !out_valid_q || rsp_o.ready;
      default: begin
        accept = 1'b0;
      end
    endcase
  end

  assign req_i.ready = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_INSERTED;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (cell_ctrl.insert) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.valid) begin
      action_q <= req_i.action;
      dep_q    <= req_i.departure_minute;
      arr_q    <= req_i.arrival_minute;
      qry_q    <= req_i.query_minute;
    end
  end

  // --------------------------------------------------------------------------
  // Query scan at the head of the chain. The head is compared with the entry
  // seen one step earlier; the first bracketing pair decides, and the earlier
  // entry wins when the query is at or below the rounded-down midpoint.
  // A query below the first departure takes the first entry, and a query
  // past every pair falls through to the last entry.
  // --------------------------------------------------------------------------
  entry_t           head;
  logic             step_live;
  logic             is_last;
  logic             bracket;
  logic [MIN_W:0]   pair_sum;
  logic [MIN_W-1:0] mid;

  assign head      = cell_entry[0];
  assign step_live = {1'b0, step_q} < count_q;
  assign is_last   = {1'b0, step_q} == (count_q - CNT_W'(1));
  assign bracket   = (step_q != '0) && (qry_q >= prev_q.dep) && (qry_q <= head.dep);
  assign pair_sum  = {1'b0, prev_q.dep} + {1'b0, head.dep};
  assign mid       = pair_sum[MIN_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      found_q <= 1'b0;
    end else if (accept) begin
      step_q  <= '0;
      found_q <= 1'b0;
    end else if (cell_ctrl.rotate) begin
      step_q <= step_q + IDX_W'(1);
      if (step_live && !found_q && (bracket || is_last ||
          ((step_q == '0) && (head.dep > qry_q)))) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_ctrl.rotate) begin
      prev_q <= head;
      if (step_live && !found_q) begin
        if (bracket) begin
          pick_q <= (qry_q <= mid) ? prev_q : head;
        end else if (is_last || ((step_q == '0) && (head.dep > qry_q))) begin
          pick_q <= head;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It holds a finished result while the controller already
  // works on the next transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_dep_q    <= (status_q == ST_MATCHED) ? pick_q.dep : '0;
      out_arr_q    <= (status_q == ST_MATCHED) ? pick_q.arr : '0;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.found_departure = out_dep_q;
  assign rsp_o.found_arrival   = out_arr_q;
  assign rsp_o.status          = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_count_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q) == S_INSERT)
    else $error("entry count changed outside an insert");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |-> (!table_full && action_q == ACT_INSERT))
    else $error("insert started on a full table");

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (!table_empty && action_q == ACT_QUERY))
    else $error("scan started on an empty table");

  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && status_q == ST_MATCHED) |-> found_q)
    else $error("query result without a picked entry");

endmodule

`default_nettype wire
